// File: rtl/spp_pkg.sv
package spp_pkg;

	// parser phase
	typedef enum logic [1:0] {
		PH_SCOPE  = 2'd0,
		PH_RIGHTS = 2'd1,
		PH_HALT   = 2'd2
	} phase_t;

	// clause operator
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_SET = 2'd2
	} op_t;

	// character classes seen by the back end
	typedef enum logic [3:0] {
		TK_U,
		TK_G,
		TK_O,
		TK_A,
		TK_PLUS,
		TK_MINUS,
		TK_EQ,
		TK_R,
		TK_W,
		TK_X,
		TK_COMMA,
		TK_OTHER
	} tok_t;

	localparam logic [2:0] CLS_U   = 3'b100;
	localparam logic [2:0] CLS_G   = 3'b010;
	localparam logic [2:0] CLS_O   = 3'b001;
	localparam logic [2:0] CLS_ALL = 3'b111;

	localparam logic [2:0] RT_R = 3'b100;
	localparam logic [2:0] RT_W = 3'b010;
	localparam logic [2:0] RT_X = 3'b001;

	localparam logic [8:0] MASK_U   = 9'o700;
	localparam logic [8:0] MASK_G   = 9'o070;
	localparam logic [8:0] MASK_O   = 9'o007;
	localparam logic [8:0] MASK_ALL = 9'o777;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// one classified character on its way to the back end
	typedef struct packed {
		tok_t       tok;
		logic       first;
		logic       last;
		logic [8:0] current_mode;
	} tok_beat_t;

	typedef struct packed {
		logic       valid;
		logic [8:0] mode;
	} finish_t;

	function automatic tok_t classify(input logic [7:0] c);
		tok_t t;
		unique case (c)
			"u":     t = TK_U;
			"g":     t = TK_G;
			"o":     t = TK_O;
			"a":     t = TK_A;
			"+":     t = TK_PLUS;
			"-":     t = TK_MINUS;
			"=":     t = TK_EQ;
			"r":     t = TK_R;
			"w":     t = TK_W;
			"x":     t = TK_X;
			",":     t = TK_COMMA;
			default: t = TK_OTHER;
		endcase
		return t;
	endfunction

	function automatic logic [8:0] class_mask(input logic [2:0] cls);
		logic [8:0] m;
		m = '0;
		if (cls[2]) m = m | MASK_U;
		if (cls[1]) m = m | MASK_G;
		if (cls[0]) m = m | MASK_O;
		return m;
	endfunction

	// applies a finished clause to the running mode
	function automatic finish_t finish_clause(input logic [8:0] run, input logic [2:0] cls,
			input op_t op, input logic [2:0] rights);
		finish_t    f;
		logic [8:0] mask;
		logic [8:0] spread;
		mask   = class_mask(cls);
		spread = {rights, rights, rights} & mask;
		f.valid = (rights != 3'b000) || (op == OP_SET);
		unique case (op)
			OP_ADD:  f.mode = run | spread;
			OP_SUB:  f.mode = run & ~spread;
			OP_SET:  f.mode = (run & ~mask) | spread;
			default: f.mode = run;
		endcase
		return f;
	endfunction

endpackage

// File: rtl/spp_cmd_if.sv
interface spp_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       first;
	logic       last;
	logic [8:0] current_mode;

	modport source (output valid, output ch, output first, output last,
		output current_mode, input ready);
	modport sink (input valid, input ch, input first, input last,
		input current_mode, output ready);
endinterface

// File: rtl/spp_res_if.sv
interface spp_res_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic [8:0] mode;

	modport source (output valid, output ok, output mode, input ready);
	modport sink (input valid, input ok, input mode, output ready);
endinterface

// File: rtl/symbolic_permission_parser.sv
// Symbolic permission parser: takes a chmod-style command such as "u+x,go=r" one
// character per beat on cmd, with first marking the opening character (current_mode is
// sampled there) and last the closing one. Each last beat yields one result beat on res:
// ok=1 with the updated rwxrwxrwx mode, or ok=0 with the mode sampled on first if the
// command had any syntax error (bad character, repeated scope or right, 'a' mixed with
// other classes, operator with no scope, empty rights with + or -, trailing comma or a
// clause cut short). After a last beat, or after an error, characters are ignored until
// the next first. The block takes one character per cycle while its queue has room: a
// front stage classifies it, and a two-entry queue decouples it from the back end, whose
// clause update sets the rate. A character passes the front stage register and a queue
// entry before the back end takes it, and the result register loads when the back end
// takes the last beat; only a last beat waits for a stalled result register, all other
// beats flow through.
module symbolic_permission_parser (
	input  logic     clk,
	input  logic     arst_n,
	spp_cmd_if.sink  cmd,
	spp_res_if.source res
);
	import spp_pkg::*;

	// front to queue
	logic      f_valid;
	logic      f_ready;
	tok_beat_t f_beat;

	// queue to back end
	logic      b_valid;
	logic      b_ready;
	tok_beat_t b_beat;

	// character classification, one beat per cycle while the queue has room
	spp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok_beat  (f_beat)
	);

	// lets the front keep accepting while the back end waits on res
	spp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_beat  (f_beat),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_beat   (b_beat)
	);

	// clause state machine and result register
	spp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (b_valid),
		.tok_ready (b_ready),
		.tok_beat  (b_beat),
		.res       (res)
	);
endmodule

// File: rtl/spp_front.sv
module spp_front (
	input  logic                clk,
	input  logic                arst_n,
	spp_cmd_if.sink             cmd,
	output logic                tok_valid,
	input  logic                tok_ready,
	output spp_pkg::tok_beat_t  tok_beat
);
	import spp_pkg::*;

	logic      valid_s1;
	tok_beat_t beat_s1;

	// stage register refills whenever it is empty or drains this cycle
	assign cmd.ready = !valid_s1 || tok_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			beat_s1.tok          <= classify(cmd.ch);
			beat_s1.first        <= cmd.first;
			beat_s1.last         <= cmd.last;
			beat_s1.current_mode <= cmd.current_mode;
		end
	end

	assign tok_valid = valid_s1;
	assign tok_beat  = beat_s1;
endmodule

// File: rtl/spp_queue.sv
module spp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  spp_pkg::tok_beat_t  push_beat,
	output logic                pop_valid,
	input  logic                pop_ready,
	output spp_pkg::tok_beat_t  pop_beat
);
	import spp_pkg::*;

	tok_beat_t          mem [Q_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != QCNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_beat   = mem[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_beat;
	end
endmodule

// File: rtl/spp_back.sv
module spp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	output logic                tok_ready,
	input  spp_pkg::tok_beat_t  tok_beat,
	spp_res_if.source           res
);
	import spp_pkg::*;

	logic [8:0] orig_q;
	logic [8:0] run_q;
	phase_t     phase_q;
	logic [2:0] cls_q;
	logic       all_q;
	op_t        op_q;
	logic [2:0] rights_q;

	logic       out_valid_q;
	logic       out_ok_q;
	logic [8:0] out_mode_q;

	logic [8:0] orig_d;
	logic [8:0] run_d;
	phase_t     phase_d;
	logic [2:0] cls_d;
	logic       all_d;
	op_t        op_d;
	logic [2:0] rights_d;
	logic       ok_d;
	logic [8:0] mode_d;
	logic [2:0] bit_c;
	finish_t    fin;
	logic       take;

	// a non-final beat never needs the result register
	assign tok_ready = !tok_beat.last || !out_valid_q || res.ready;
	assign take      = tok_valid && tok_ready;

	always_comb begin
		if (tok_beat.first) begin
			orig_d   = tok_beat.current_mode;
			run_d    = tok_beat.current_mode;
			phase_d  = PH_SCOPE;
			cls_d    = '0;
			all_d    = 1'b0;
			op_d     = OP_ADD;
			rights_d = '0;
		end else begin
			orig_d   = orig_q;
			run_d    = run_q;
			phase_d  = phase_q;
			cls_d    = cls_q;
			all_d    = all_q;
			op_d     = op_q;
			rights_d = rights_q;
		end

		unique case (tok_beat.tok)
			TK_U, TK_R: bit_c = 3'b100;
			TK_G, TK_W: bit_c = 3'b010;
			TK_O, TK_X: bit_c = 3'b001;
			default:    bit_c = 3'b000;
		endcase

		fin = finish_clause(run_d, cls_d, op_d, rights_d);

		unique case (phase_d)
			PH_SCOPE: begin
				unique case (tok_beat.tok)
					TK_U, TK_G, TK_O: begin
						if (((cls_d & bit_c) != '0) || all_d) phase_d = PH_HALT;
						else cls_d = cls_d | bit_c;
					end
					TK_A: begin
						if (all_d || (cls_d != '0)) begin
							phase_d = PH_HALT;
						end else begin
							all_d = 1'b1;
							cls_d = CLS_ALL;
						end
					end
					TK_PLUS, TK_MINUS, TK_EQ: begin
						if (cls_d == '0) begin
							phase_d = PH_HALT;
						end else begin
							unique case (tok_beat.tok)
								TK_PLUS:  op_d = OP_ADD;
								TK_MINUS: op_d = OP_SUB;
								default:  op_d = OP_SET;
							endcase
							rights_d = '0;
							phase_d  = PH_RIGHTS;
						end
					end
					default: phase_d = PH_HALT;
				endcase
			end
			PH_RIGHTS: begin
				unique case (tok_beat.tok)
					TK_R, TK_W, TK_X: begin
						if ((rights_d & bit_c) != '0) phase_d = PH_HALT;
						else rights_d = rights_d | bit_c;
					end
					TK_COMMA: begin
						// rights untouched by the comma, so fin is this clause
						if (!fin.valid) begin
							phase_d = PH_HALT;
						end else begin
							run_d    = fin.mode;
							cls_d    = '0;
							all_d    = 1'b0;
							op_d     = OP_ADD;
							rights_d = '0;
							phase_d  = PH_SCOPE;
						end
					end
					default: phase_d = PH_HALT;
				endcase
			end
			default: ;
		endcase

		// end of command: rights phase is the only valid place to stop
		ok_d   = 1'b0;
		mode_d = orig_d;
		if (tok_beat.last) begin
			fin  = finish_clause(run_d, cls_d, op_d, rights_d);
			ok_d = (phase_d == PH_RIGHTS) && fin.valid;
			if (ok_d) begin
				run_d  = fin.mode;
				mode_d = fin.mode;
			end
			phase_d  = PH_HALT;
			cls_d    = '0;
			all_d    = 1'b0;
			op_d     = OP_ADD;
			rights_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_q      <= '0;
			run_q       <= '0;
			phase_q     <= PH_SCOPE;
			cls_q       <= '0;
			all_q       <= 1'b0;
			op_q        <= OP_ADD;
			rights_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				orig_q   <= orig_d;
				run_q    <= run_d;
				phase_q  <= phase_d;
				cls_q    <= cls_d;
				all_q    <= all_d;
				op_q     <= op_d;
				rights_q <= rights_d;
			end
			if (take && tok_beat.last) out_valid_q <= 1'b1;
			else if (res.ready)        out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && tok_beat.last) begin
			out_ok_q   <= ok_d;
			out_mode_q <= mode_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.ok    = out_ok_q;
	assign res.mode  = out_mode_q;
endmodule
